### rtl/core/avgseg_pkg.sv
// ----------------------------------------------------------------------------
// avgseg_pkg
// Shared constants, types and the digit segment table of the averaged
// sample to seven-segment display driver.
// ----------------------------------------------------------------------------
package avgseg_pkg;

   // block configuration
   localparam int SAMPLES_PER_UPDATE = 8;
   localparam int DISPLAY_DIGITS     = 6;

   // field widths
   localparam int SAMPLE_W    = 10;
   localparam int SCALE_W     = 10;
   localparam int SCALE_SHIFT = 10;
   localparam int SEG_W       = 8;

   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(625);
   localparam logic [SEG_W-1:0]   SEG_BLANK   = '0;
   localparam logic [3:0]         DIGIT_NINE  = 4'd9;

   // derived widths
   localparam int SUM_W   = SAMPLE_W + $clog2(SAMPLES_PER_UPDATE);
   localparam int COUNT_W = (SAMPLES_PER_UPDATE > 1) ? $clog2(SAMPLES_PER_UPDATE) : 1;
   localparam int PROD_W  = SUM_W + SCALE_W;
   localparam int VAL_W   = PROD_W - SCALE_SHIFT;
   localparam int MCNT_W  = $clog2(SCALE_W + 1);
   localparam int BCNT_W  = $clog2(VAL_W + 1);

   // decimal digits needed to hold any value
   localparam int BCD_DIGITS = (VAL_W * 3) / 10 + 1;
   localparam int NUM_W      = $clog2(BCD_DIGITS + 1);
   localparam int MAX_DIGITS = (BCD_DIGITS > DISPLAY_DIGITS) ? BCD_DIGITS : DISPLAY_DIGITS;
   localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W      = (BCD_DIGITS > 1) ? $clog2(BCD_DIGITS) : 1;

   // conversion result handed to the byte sequencer
   typedef struct packed {
      logic [BCD_DIGITS-1:0][3:0] digit;
      logic [NUM_W-1:0]           num;
   } bcd_result_type;

   // segment pattern of one decimal digit
   function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] d);
      logic [SEG_W-1:0] p;
      case (d)
         4'd0:    p = 8'hEE;
         4'd1:    p = 8'h82;
         4'd2:    p = 8'hDC;
         4'd3:    p = 8'hD6;
         4'd4:    p = 8'hB2;
         4'd5:    p = 8'h76;
         4'd6:    p = 8'h7E;
         4'd7:    p = 8'hC2;
         4'd8:    p = 8'hFE;
         4'd9:    p = 8'hF6;
         default: p = SEG_BLANK;
      endcase
      return p;
   endfunction

endpackage

### rtl/core/avgseg_mult.sv
// ----------------------------------------------------------------------------
// avgseg_mult
// Bit-serial shift-and-add multiplier: sum times scale, one scale bit per
// cycle, result shifted right by the scale shift.
// ----------------------------------------------------------------------------
module avgseg_mult (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [avgseg_pkg::SUM_W-1:0]   mcand,
   input  logic [avgseg_pkg::SCALE_W-1:0] mplier,
   output logic                           done,
   output logic [avgseg_pkg::VAL_W-1:0]   value
);
   import avgseg_pkg::*;

   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [MCNT_W-1:0]   cnt_ff, cnt_in;
   logic [PROD_W-1:0]   acc_ff, acc_in;
   logic [PROD_W-1:0]   mcand_ff, mcand_in;
   logic [SCALE_W-1:0]  mplier_ff, mplier_in;

   // one partial product per cycle
   always_comb begin
      run_in    = run_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (start) begin
         run_in    = 1'b1;
         cnt_in    = '0;
         acc_in    = '0;
         mcand_in  = PROD_W'(mcand);
         mplier_in = mplier;
      end else if (run_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[PROD_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[SCALE_W-1:1]};
         cnt_in    = cnt_ff + MCNT_W'(1);
         if (cnt_ff == MCNT_W'(SCALE_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign done  = done_ff;
   assign value = acc_ff[PROD_W-1:SCALE_SHIFT];

endmodule

### rtl/core/avgseg_bcd.sv
// ----------------------------------------------------------------------------
// avgseg_bcd
// Bit-serial binary to decimal conversion (shift and add three), one
// binary bit per cycle, plus the count of significant digits.
// ----------------------------------------------------------------------------
module avgseg_bcd (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [avgseg_pkg::VAL_W-1:0]       value,
   output logic                               done,
   output avgseg_pkg::bcd_result_type         result
);
   import avgseg_pkg::*;

   logic                        run_ff, run_in;
   logic                        done_ff, done_in;
   logic [BCNT_W-1:0]           cnt_ff, cnt_in;
   logic [VAL_W-1:0]            bin_ff, bin_in;
   logic [BCD_DIGITS*4-1:0]     bcd_ff, bcd_in;
   logic [BCD_DIGITS*4-1:0]     adj;
   logic [NUM_W-1:0]            num;

   // add three to every digit of five or more
   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                     : bcd_ff[i*4 +: 4];
      end
   end

   // shift one binary bit into the digit register
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         bin_in = value;
         bcd_in = '0;
      end else if (run_ff) begin
         bcd_in = {adj[BCD_DIGITS*4-2:0], bin_ff[VAL_W-1]};
         bin_in = {bin_ff[VAL_W-2:0], 1'b0};
         cnt_in = cnt_ff + BCNT_W'(1);
         if (cnt_ff == BCNT_W'(VAL_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // significant digits, at least one
   always_comb begin
      num = NUM_W'(1);
      for (int i = 1; i < BCD_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] != 4'd0) begin
            num = NUM_W'(i + 1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign done         = done_ff;
   assign result.digit = bcd_ff;
   assign result.num   = num;

endmodule

### rtl/core/avgseg_emit.sv
// ----------------------------------------------------------------------------
// avgseg_emit
// Byte sequencer: clearing bytes, then one segment byte per digit, most
// significant first, through a registered output stage.
// ----------------------------------------------------------------------------
module avgseg_emit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  avgseg_pkg::bcd_result_type     result,
   output logic                           fin,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [avgseg_pkg::SEG_W-1:0]   rsp_segments,
   output logic                           rsp_blank,
   output logic                           rsp_last
);
   import avgseg_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BLANK,
      ST_DIGIT
   } state_type;

   state_type                   state_ff, state_in;
   logic [CNT_W-1:0]            blk_ff, blk_in;
   logic [CNT_W-1:0]            rem_ff, rem_in;
   logic                        sat_ff, sat_in;
   logic [BCD_DIGITS-1:0][3:0]  dig_ff, dig_in;
   logic                        valid_ff, valid_in;
   logic [SEG_W-1:0]            seg_ff, seg_in;
   logic                        blank_ff, blank_in;
   logic                        last_ff, last_in;
   logic                        fin_ff, fin_in;
   logic                        out_free;
   logic                        sat_now;
   logic [CNT_W-1:0]            rem_m1;
   logic [IDX_W-1:0]            idx;

   assign out_free = !valid_ff || !rsp_stall;
   assign sat_now  = CNT_W'(result.num) > CNT_W'(DISPLAY_DIGITS);
   assign rem_m1   = rem_ff - CNT_W'(1);
   assign idx      = rem_m1[IDX_W-1:0];

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      blk_in   = blk_ff;
      rem_in   = rem_ff;
      sat_in   = sat_ff;
      dig_in   = dig_ff;
      valid_in = valid_ff;
      seg_in   = seg_ff;
      blank_in = blank_ff;
      last_in  = last_ff;
      fin_in   = 1'b0;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               dig_in   = result.digit;
               sat_in   = sat_now;
               rem_in   = sat_now ? CNT_W'(DISPLAY_DIGITS) : CNT_W'(result.num);
               blk_in   = CNT_W'(DISPLAY_DIGITS);
               state_in = ST_BLANK;
            end
         end
         ST_BLANK: begin
            if (out_free) begin
               valid_in = 1'b1;
               seg_in   = SEG_BLANK;
               blank_in = 1'b1;
               last_in  = 1'b0;
               blk_in   = blk_ff - CNT_W'(1);
               if (blk_ff == CNT_W'(1)) begin
                  state_in = ST_DIGIT;
               end
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               valid_in = 1'b1;
               seg_in   = sat_ff ? seg_pattern(DIGIT_NINE) : seg_pattern(dig_ff[idx]);
               blank_in = 1'b0;
               last_in  = (rem_ff == CNT_W'(1));
               rem_in   = rem_m1;
               if (rem_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
                  fin_in   = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         fin_ff   <= fin_in;
      end
      blk_ff   <= blk_in;
      rem_ff   <= rem_in;
      sat_ff   <= sat_in;
      dig_ff   <= dig_in;
      seg_ff   <= seg_in;
      blank_ff <= blank_in;
      last_ff  <= last_in;
   end

   assign fin          = fin_ff;
   assign rsp_valid    = valid_ff;
   assign rsp_segments = seg_ff;
   assign rsp_blank    = blank_ff;
   assign rsp_last     = last_ff;

endmodule

### rtl/core/averaged_sample_to_seven_segment_top.sv
// Non-update samples are taken one per cycle unless the input is stalled, and are
// only added to the running sum. The update sample starts the serial multiply,
// which in turn starts the serial decimal conversion and then the byte sequencer.
// Bytes then leave one per cycle (6 blanks plus 1 to 4 digits) unless stalled.
// Input stalls from the update sample to the cycle after the last byte registers.
// Synchronous active-high reset clears sum, count and handshakes; scale is 625.
// ----------------------------------------------------------------------------
// averaged_sample_to_seven_segment_top
// Sums converter samples, scales every eighth sum and drives the display
// chain with clearing bytes and segment-pattern bytes.
// ----------------------------------------------------------------------------
module averaged_sample_to_seven_segment_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [avgseg_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [avgseg_pkg::SEG_W-1:0]      rsp_segments,
   output logic                              rsp_blank,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [avgseg_pkg::SCALE_W-1:0]    csr_scale_factor
);
   import avgseg_pkg::*;

   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [SCALE_W-1:0]  scale_ff, scale_in;
   logic                busy_ff, busy_in;
   logic                req_accept;
   logic                final_sample;
   logic [SUM_W-1:0]    sum_next;
   logic                mult_done;
   logic [VAL_W-1:0]    mult_value;
   logic                bcd_done;
   bcd_result_type      bcd_result;
   logic                emit_fin;

   assign csr_ready    = 1'b1;
   assign req_stall    = busy_ff;
   assign req_accept   = req_valid && !busy_ff;
   assign final_sample = (count_ff == COUNT_W'(SAMPLES_PER_UPDATE - 1));
   assign sum_next     = sum_ff + SUM_W'(req_sample);

   // accumulate samples, clear after the update sample
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      scale_in = scale_ff;
      busy_in  = busy_ff;
      if (csr_valid && csr_ready) begin
         scale_in = csr_scale_factor;
      end
      if (req_accept) begin
         if (final_sample) begin
            sum_in   = '0;
            count_in = '0;
            busy_in  = 1'b1;
         end else begin
            sum_in   = sum_next;
            count_in = count_ff + COUNT_W'(1);
         end
      end else if (emit_fin) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         scale_ff <= SCALE_RESET;
         busy_ff  <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         scale_ff <= scale_in;
         busy_ff  <= busy_in;
      end
   end

   // serial scale multiply
   avgseg_mult u_mult (
      .clock  (clock),
      .reset  (reset),
      .start  (req_accept && final_sample),
      .mcand  (sum_next),
      .mplier (scale_ff),
      .done   (mult_done),
      .value  (mult_value)
   );

   // serial decimal conversion
   avgseg_bcd u_bcd (
      .clock  (clock),
      .reset  (reset),
      .start  (mult_done),
      .value  (mult_value),
      .done   (bcd_done),
      .result (bcd_result)
   );

   // display byte sequencer
   avgseg_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .start        (bcd_done),
      .result       (bcd_result),
      .fin          (emit_fin),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_segments (rsp_segments),
      .rsp_blank    (rsp_blank),
      .rsp_last     (rsp_last)
   );

endmodule

### rtl/core/avgseg_chk.sv
// ----------------------------------------------------------------------------
// avgseg_chk
// Port-level checks on the display byte stream, bound to the top level.
// ----------------------------------------------------------------------------
module avgseg_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [avgseg_pkg::SEG_W-1:0]      rsp_segments,
   input logic                              rsp_blank,
   input logic                              rsp_last
);
   import avgseg_pkg::*;

   // no transaction offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled transaction stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // clearing bytes are zero and never close an update
   a_blank_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_blank |-> (rsp_segments == SEG_BLANK) && !rsp_last)
      else $error("clearing byte not zero or marked last");

   // every digit pattern lights at least one segment
   a_digit_lit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_blank |-> rsp_segments != SEG_BLANK)
      else $error("digit byte with no segments");

endmodule

bind averaged_sample_to_seven_segment_top avgseg_chk u_avgseg_chk (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_segments (rsp_segments),
   .rsp_blank    (rsp_blank),
   .rsp_last     (rsp_last)
);
